@@ hw/rtl/wtm_pkg.sv @@
// wtm_pkg: shared constants, codes and types for the windowed trimmed-mean block
// depends on nothing; imported by every module of the block
package wtm_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int WINDOW_DEPTH = 16;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int FILL_W       = IDX_W + 1;
   localparam int TRIM_LOW     = 4;
   localparam int TRIM_HIGH    = 12;
   localparam int TRIM_SHIFT   = 3;
   localparam int SUM_W        = SAMPLE_W + TRIM_SHIFT;

   localparam logic [SAMPLE_W-1:0] DIFF_OFFSET = SAMPLE_W'(20000);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SRC_SEL_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_SELECT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_BOUNDARY      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_WIDTH = 2'd2;

   localparam logic [SRC_SEL_W-1:0] SRC_DIFFERENCE = 2'd0;
   localparam logic [SRC_SEL_W-1:0] SRC_SENSE      = 2'd1;
   localparam logic [SRC_SEL_W-1:0] SRC_REFERENCE  = 2'd2;

   localparam logic [SAMPLE_W-1:0]  ON_BOUNDARY_RST      = SAMPLE_W'(19750);
   localparam logic [SAMPLE_W-1:0]  HYSTERESIS_WIDTH_RST = SAMPLE_W'(70);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_SUM,
      ST_FLAG
   } state_type;

   // sequencer to sorted window controls, sorted window status back
   typedef struct packed {
      logic remove;
      logic insert;
      logic sum;
   } sort_ctrl_type;

   typedef struct packed {
      logic full;
   } sort_stat_type;

endpackage

@@ hw/rtl/wtm_if.sv @@
// wtm_if: valid/ready channel interfaces for the request and response words
// depends on wtm_pkg for field widths
interface wtm_req_if;
   logic                          valid;
   logic                          ready;
   logic [wtm_pkg::SAMPLE_W-1:0]  sense_count;
   logic [wtm_pkg::SAMPLE_W-1:0]  reference_count;

   modport source (output valid, output sense_count, output reference_count, input ready);
   modport sink   (input valid, input sense_count, input reference_count, output ready);
endinterface

interface wtm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wtm_pkg::SAMPLE_W-1:0]  level_estimate;
   logic                          presence_flag;

   modport source (output valid, output level_estimate, output presence_flag,
                   input ready);
   modport sink   (input valid, input level_estimate, input presence_flag,
                   output ready);
endinterface

@@ hw/rtl/wtm_ring.sv @@
// wtm_ring: sample ring memory with its write pointer
// depends on wtm_pkg; read-before-write returns the oldest sample one cycle later
module wtm_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [wtm_pkg::SAMPLE_W-1:0]  wr_data,
   output logic [wtm_pkg::SAMPLE_W-1:0]  old_data
);
   import wtm_pkg::*;

   logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] old_data_ff;
   logic [IDX_W-1:0]    wpos_ff;
   logic [IDX_W-1:0]    wpos_in;

   assign wpos_in  = wr_en ? wpos_ff + IDX_W'(1) : wpos_ff;
   assign old_data = old_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
      end else begin
         wpos_ff <= wpos_in;
      end
   end

   // entry being overwritten comes out on the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         old_data_ff      <= ring_mem[wpos_ff];
         ring_mem[wpos_ff] <= wr_data;
      end
   end

endmodule

@@ hw/rtl/wtm_sort_window.sv @@
// wtm_sort_window: ascending copy of the window with remove, insert and estimate
// depends on wtm_pkg; driven by the sequencer in the top level
module wtm_sort_window (
   input  logic                          clock,
   input  logic                          reset,
   input  wtm_pkg::sort_ctrl_type        ctrl,
   input  logic [wtm_pkg::SAMPLE_W-1:0]  old_sample,
   input  logic [wtm_pkg::SAMPLE_W-1:0]  new_sample,
   output wtm_pkg::sort_stat_type        stat,
   output logic [wtm_pkg::SAMPLE_W-1:0]  estimate
);
   import wtm_pkg::*;

   logic [SAMPLE_W-1:0] sorted_ff [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] sorted_in [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] removed   [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] inserted  [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] le_new;
   logic [FILL_W-1:0]   cnt_ff;
   logic [FILL_W-1:0]   cnt_in;
   logic [SAMPLE_W-1:0] est_ff;
   logic [SAMPLE_W-1:0] est_in;
   logic [SUM_W-1:0]    trim_sum;
   logic                full;

   assign full      = (cnt_ff == FILL_W'(WINDOW_DEPTH));
   assign stat.full = full;
   assign estimate  = est_ff;

   // drop the first entry equal to the oldest sample, close the gap
   always_comb begin
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         hit = hit | (sorted_ff[i] == old_sample);
         if (hit && i < WINDOW_DEPTH - 1) begin
            removed[i] = sorted_ff[(i + 1) % WINDOW_DEPTH];
         end else begin
            removed[i] = sorted_ff[i];
         end
      end
   end

   // place the new sample after every valid entry not above it
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         le_new[i] = (FILL_W'(i) < cnt_ff) && (sorted_ff[i] <= new_sample);
      end
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (le_new[i]) begin
            inserted[i] = sorted_ff[i];
         end else if (i == 0) begin
            inserted[i] = new_sample;
         end else if (le_new[(i + WINDOW_DEPTH - 1) % WINDOW_DEPTH]) begin
            inserted[i] = new_sample;
         end else begin
            inserted[i] = sorted_ff[(i + WINDOW_DEPTH - 1) % WINDOW_DEPTH];
         end
      end
   end

   always_comb begin
      trim_sum = '0;
      for (int i = TRIM_LOW; i < TRIM_HIGH; i++) begin
         trim_sum = trim_sum + SUM_W'(sorted_ff[i]);
      end
   end

   always_comb begin
      sorted_in = sorted_ff;
      cnt_in    = cnt_ff;
      est_in    = est_ff;
      if (ctrl.remove) begin
         sorted_in = removed;
         cnt_in    = cnt_ff - FILL_W'(1);
      end else if (ctrl.insert) begin
         sorted_in = inserted;
         cnt_in    = cnt_ff + FILL_W'(1);
      end
      if (ctrl.sum) begin
         if (full) begin
            est_in = SAMPLE_W'(trim_sum >> TRIM_SHIFT);
         end else begin
            est_in = sorted_ff[cnt_ff[FILL_W-1:1]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sorted_ff <= sorted_in;
      est_ff    <= est_in;
   end

endmodule

@@ hw/rtl/windowed_trimmed_mean_hysteresis.sv @@
// windowed_trimmed_mean_hysteresis: top level, sequencer, csr bank and presence flag
// depends on wtm_pkg, wtm_if, wtm_ring and wtm_sort_window
//
//  channel   dir  handshake          word
//  req_chan  in   valid/ready        sense_count, reference_count
//  rsp_chan  out  valid/ready        level_estimate, presence_flag
//  csr_*     in   csr_wr_en only     csr_index, csr_wr_data
//
// one word passes through the idle step in which it is accepted and the ring
// written, then remove oldest from the sorted copy, insert, estimate, flag update;
// the response register loads in the flag update step.
// the sequencer handles one word at a time; the ring port and the sorted copy
// are the shared resources behind this.
// reset is synchronous and active high; it empties the window and clears the flag.
// a response still waiting holds the sequencer in its last step only; once it is
// taken the new response loads and the sequencer returns to idle for the next word.
module windowed_trimmed_mean_hysteresis (
   input  logic                            clock,
   input  logic                            reset,
   wtm_req_if.sink                         req_chan,
   wtm_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [wtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wtm_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import wtm_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   sort_ctrl_type         sort_ctrl;
   sort_stat_type         sort_stat;

   logic [SRC_SEL_W-1:0]  src_sel_ff;
   logic [SAMPLE_W-1:0]   boundary_ff;
   logic [SAMPLE_W-1:0]   hyst_width_ff;

   logic [SAMPLE_W-1:0]   sample_ff;
   logic [SAMPLE_W-1:0]   sample_in;
   logic [SAMPLE_W-1:0]   old_sample;
   logic [SAMPLE_W-1:0]   estimate;

   logic                  presence_ff;
   logic                  presence_in;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   rsp_est_ff;
   logic                  rsp_flag_ff;

   logic                  req_take;
   logic                  load_rsp;
   logic [SAMPLE_W:0]     clear_level;

   // csr bank, writes beyond the list fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         src_sel_ff    <= SRC_DIFFERENCE;
         boundary_ff   <= ON_BOUNDARY_RST;
         hyst_width_ff <= HYSTERESIS_WIDTH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE_SELECT:    src_sel_ff    <= csr_wr_data[SRC_SEL_W-1:0];
            CSR_ON_BOUNDARY:      boundary_ff   <= csr_wr_data[SAMPLE_W-1:0];
            CSR_HYSTERESIS_WIDTH: hyst_width_ff <= csr_wr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // sample source; the unused select code falls back to the biased difference
   always_comb begin
      case (src_sel_ff)
         SRC_SENSE:     sample_in = req_chan.sense_count;
         SRC_REFERENCE: sample_in = req_chan.reference_count;
         default:       sample_in = DIFF_OFFSET + req_chan.sense_count
                                    - req_chan.reference_count;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= sample_in;
      end
   end

   wtm_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_take),
      .wr_data  (sample_in),
      .old_data (old_sample)
   );

   wtm_sort_window u_sort (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sort_ctrl),
      .old_sample (old_sample),
      .new_sample (sample_ff),
      .stat       (sort_stat),
      .estimate   (estimate)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sort_ctrl = '0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            // the oldest sample only leaves a full window
            sort_ctrl.remove = sort_stat.full;
            state_in         = ST_INSERT;
         end
         ST_INSERT: begin
            sort_ctrl.insert = 1'b1;
            state_in         = ST_SUM;
         end
         ST_SUM: begin
            sort_ctrl.sum = 1'b1;
            state_in      = ST_FLAG;
         end
         ST_FLAG: begin
            // wait here while the previous response has not been taken
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // presence with hysteresis, clear level formed at 17 bits without wrap
   assign clear_level = {1'b0, boundary_ff} + {1'b0, hyst_width_ff};

   always_comb begin
      presence_in = presence_ff;
      if (!presence_ff) begin
         if (estimate <= boundary_ff) begin
            presence_in = 1'b1;
         end
      end else if ({1'b0, estimate} >= clear_level) begin
         presence_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            presence_ff  <= presence_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_est_ff  <= estimate;
         rsp_flag_ff <= presence_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.level_estimate = rsp_est_ff;
   assign rsp_chan.presence_flag  = rsp_flag_ff;

endmodule

@@ sim/wtm_checker.sv @@
`timescale 1ns / 1ps
// wtm_checker: watches the request, response and csr ports of the window block,
// predicts each response word and compares it field by field
// depends on wtm_pkg for widths, register indexes and source codes
module wtm_checker
   import wtm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sense,
   input  logic [SAMPLE_W-1:0]   req_reference,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SAMPLE_W-1:0]   rsp_estimate,
   input  logic                  rsp_presence,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    outstanding,
   output int                    words_checked,
   output int                    full_window_words,
   output int                    presence_changes
);

   typedef struct packed {
      logic [SAMPLE_W-1:0] estimate;
      logic                presence;
   } window_word_type;

   logic [SAMPLE_W-1:0]  sample_history [WINDOW_DEPTH];
   logic [IDX_W-1:0]     history_pos;
   logic [FILL_W-1:0]    history_fill;
   logic                 water_present;
   logic [SRC_SEL_W-1:0] sample_source;
   logic [SAMPLE_W-1:0]  set_boundary;
   logic [SAMPLE_W-1:0]  clear_width;
   window_word_type      pending_estimates [$];
   int                   mismatches;
   int                   checked;
   int                   full_words;
   int                   changes;

   // unused select code falls back to the biased difference, wrapped at 16 bits
   function automatic logic [SAMPLE_W-1:0] form_sample(input logic [SRC_SEL_W-1:0] sel,
                                                       input logic [SAMPLE_W-1:0] sense,
                                                       input logic [SAMPLE_W-1:0] refc);
      case (sel)
         SRC_SENSE:     return sense;
         SRC_REFERENCE: return refc;
         default:       return DIFF_OFFSET + sense - refc;
      endcase
   endfunction

   // median while filling, trimmed mean of the middle ranks once full
   function automatic logic [SAMPLE_W-1:0] predict_level();
      logic [SAMPLE_W-1:0] ranked [WINDOW_DEPTH];
      logic [SAMPLE_W-1:0] v;
      logic [SUM_W-1:0]    acc;
      int                  n;
      int                  j;
      n = history_fill;
      for (int i = 0; i < n; i++) ranked[i] = sample_history[i];
      for (int i = 1; i < n; i++) begin
         v = ranked[i];
         j = i;
         while (j > 0 && ranked[j-1] > v) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = v;
      end
      if (n < WINDOW_DEPTH) return ranked[n/2];
      acc = '0;
      for (int i = TRIM_LOW; i < TRIM_HIGH; i++) acc += ranked[i];
      return SAMPLE_W'(acc >> TRIM_SHIFT);
   endfunction

   always @(posedge clock) begin
      window_word_type     want;
      logic [SAMPLE_W-1:0] est;
      logic                was_present;
      if (reset) begin
         sample_source = SRC_DIFFERENCE;
         set_boundary  = ON_BOUNDARY_RST;
         clear_width   = HYSTERESIS_WIDTH_RST;
         history_pos   = '0;
         history_fill  = '0;
         water_present = 1'b0;
         pending_estimates.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SOURCE_SELECT:    sample_source = csr_wr_data[SRC_SEL_W-1:0];
               CSR_ON_BOUNDARY:      set_boundary  = csr_wr_data;
               CSR_HYSTERESIS_WIDTH: clear_width   = csr_wr_data;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            checked++;
            if (pending_estimates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word: estimate %0d presence %0b",
                           rsp_estimate, rsp_presence);
            end else begin
               want = pending_estimates.pop_front();
               if (want.estimate !== rsp_estimate || want.presence !== rsp_presence) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch on word %0d: estimate exp %0d got %0d, ",
                               "presence exp %0b got %0b"},
                              checked, want.estimate, rsp_estimate, want.presence,
                              rsp_presence);
               end
            end
         end

         if (req_valid && req_ready) begin
            sample_history[history_pos] = form_sample(sample_source, req_sense, req_reference);
            history_pos = history_pos + 1'b1;
            if (history_fill < WINDOW_DEPTH) history_fill = history_fill + 1'b1;
            if (history_fill == WINDOW_DEPTH) full_words++;
            est = predict_level();
            was_present = water_present;
            // clear threshold formed at 17 bits so it never wraps
            if (!water_present) begin
               if (est <= set_boundary) water_present = 1'b1;
            end else if ({1'b0, est} >= {1'b0, set_boundary} + {1'b0, clear_width}) begin
               water_present = 1'b0;
            end
            if (was_present != water_present) changes++;
            want.estimate = est;
            want.presence = water_present;
            pending_estimates.push_back(want);
         end
      end
      mismatch_count    <= mismatches;
      outstanding       <= pending_estimates.size();
      words_checked     <= checked;
      full_window_words <= full_words;
      presence_changes  <= changes;
   end

endmodule

@@ sim/tb_windowed_trimmed_mean_hysteresis.sv @@
`timescale 1ns / 1ps
// tb_windowed_trimmed_mean_hysteresis: stimulus and verdict for the window block
// depends on wtm_pkg, wtm_if, the block itself and wtm_checker
module tb_windowed_trimmed_mean_hysteresis;
   import wtm_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_SEGMENTS = 6;
   localparam int SEGMENT_WORDS   = 255;
   // comfortably longer than one word takes to pass the sequencer end to end
   localparam int SETTLE_CYCLES   = 20;

   // codes the package leaves unnamed: a register index with nothing behind it
   // and the spare source select value
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [SRC_SEL_W-1:0] SRC_UNUSED       = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    tx_idle_pct;
   int                    rx_idle_pct;
   int                    cycle_count = 0;
   int                    mismatch_count;
   int                    outstanding;
   int                    words_checked;
   int                    full_window_words;
   int                    presence_changes;

   wtm_req_if req_bus ();
   wtm_rsp_if rsp_bus ();

   windowed_trimmed_mean_hysteresis dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   wtm_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_sense         (req_bus.sense_count),
      .req_reference     (req_bus.reference_count),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_estimate      (rsp_bus.level_estimate),
      .rsp_presence      (rsp_bus.presence_flag),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .words_checked     (words_checked),
      .full_window_words (full_window_words),
      .presence_changes  (presence_changes)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // response side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (int'($urandom_range(99, 0)) >= rx_idle_pct);
      end
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still awaited", cycle_count, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // present one request word; valid stays high into the next call unless that
   // call opens a gap, so it is never dropped and raised within one step
   task automatic send_word(input logic [SAMPLE_W-1:0] sense, input logic [SAMPLE_W-1:0] refc);
      while (int'($urandom_range(99, 0)) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.sense_count     <= sense;
      req_bus.reference_count <= refc;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // stop sending and wait for every predicted word to come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // upper bits of the select word are junk the block must mask off; the write
   // to the spare index must be ignored
   task automatic configure(input logic [SRC_SEL_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] bnd,
                            input logic [CSR_DATA_W-1:0] wid);
      write_reg(CSR_SOURCE_SELECT, {14'($urandom()), sel});
      write_reg(CSR_ON_BOUNDARY, bnd);
      write_reg(CSR_HYSTERESIS_WIDTH, wid);
      write_reg(CSR_UNUSED_INDEX, 16'($urandom()));
      csr_wr_en <= 1'b0;
   endtask

   // mostly samples that wander between wet and dry around the thresholds, so
   // the hysteresis flips in both directions; the rest is raw noise on both counts
   task automatic send_wet_dry_run(input int count, input logic [SRC_SEL_W-1:0] sel,
                                   input int bnd, input int wid);
      int                  level;
      bit                  wet;
      logic [SAMPLE_W-1:0] target;
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] r;
      wet = 1'b0;
      repeat (count) begin
         if ($urandom_range(29, 0) == 0) wet = !wet;
         level = wet ? bnd - int'($urandom_range(300, 0))
                     : bnd + wid + int'($urandom_range(300, 0));
         if (level < 0) level = 0;
         if (level > 65535) level = 65535;
         target = level[SAMPLE_W-1:0];
         if ($urandom_range(99, 0) < 15) begin
            s = 16'($urandom());
            r = 16'($urandom());
         end else begin
            case (sel)
               SRC_SENSE: begin
                  s = target;
                  r = 16'($urandom());
               end
               SRC_REFERENCE: begin
                  s = 16'($urandom());
                  r = target;
               end
               default: begin
                  // pick the reference, then solve for the sense count
                  r = 16'($urandom());
                  s = target - DIFF_OFFSET + r;
               end
            endcase
         end
         send_word(s, r);
      end
   endtask

   initial begin
      logic [SRC_SEL_W-1:0] sel;
      int                   bnd;
      int                   wid;
      req_bus.valid           <= 1'b0;
      req_bus.sense_count     <= '0;
      req_bus.reference_count <= '0;
      csr_wr_en               <= 1'b0;
      csr_index               <= CSR_SOURCE_SELECT;
      csr_wr_data             <= '0;
      tx_idle_pct = 10;
      rx_idle_pct = 62;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, biased difference with both wrap directions,
      // a low run that sets presence, a high run that clears it and fills the window
      send_word(16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'hFFFF);
      send_word(16'h0000, 16'hFFFF);
      send_word(16'hFFFF, 16'h0000);
      repeat (5) send_word(16'd0, 16'd500);
      repeat (7) send_word(16'd1000, 16'd0);
      // ring wraps over the oldest entries here
      send_word(16'd300, 16'd0);
      send_word(16'h8000, 16'h7FFF);
      settle();

      // spare select code must act as the difference
      configure(SRC_UNUSED, ON_BOUNDARY_RST, HYSTERESIS_WIDTH_RST);
      send_word(16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'h0001);
      settle();

      // top boundary and widest band: the clear threshold exceeds 16 bits
      configure(SRC_SENSE, 16'hFFFF, 16'hFFFF);
      send_word(16'hFFFF, 16'h0000);
      send_word(16'h0000, 16'hFFFF);
      settle();

      // zero boundary and zero width
      configure(SRC_REFERENCE, 16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'h0000);
      send_word(16'h0000, 16'hFFFF);
      settle();

      // random part: each segment its own settings; idling mix changes every two
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         case (seg)
            0: begin sel = SRC_DIFFERENCE; bnd = 19750; wid = 70;    end
            1: begin sel = SRC_SENSE;      bnd = 30000; wid = 500;   end
            2: begin sel = SRC_REFERENCE;  bnd = 0;     wid = 0;     end
            3: begin sel = SRC_UNUSED;     bnd = 65535; wid = 65535; end
            4: begin sel = SRC_SENSE;      bnd = 65535; wid = 0;     end
            default: begin
               sel = SRC_SEL_W'($urandom_range(3, 0));
               bnd = $urandom_range(65535, 0);
               wid = $urandom_range(2000, 0);
            end
         endcase
         if (seg < 2) begin
            tx_idle_pct = 10;
            rx_idle_pct = 62;
         end else if (seg < 4) begin
            tx_idle_pct = 62;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         configure(sel, bnd[CSR_DATA_W-1:0], wid[CSR_DATA_W-1:0]);
         send_wet_dry_run(SEGMENT_WORDS, sel, bnd, wid);
         // full drain between segments doubles as the sender hold-off
         settle();
      end

      $display("checked %0d response words, %0d of them over a full window", words_checked,
               full_window_words);
      $display("presence flag changed %0d times across all source selects and threshold extremes",
               presence_changes);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
